// ===== rtl/pnsf_pkg.sv =====
`timescale 1ns / 1ps
package pnsf_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int STATE_BITS  = 32;
   localparam int NUM_POLES   = 6;
   localparam int SAMPLE_FRAC = SAMPLE_BITS - 1;
   localparam int STATE_FRAC  = STATE_BITS - 9;
   localparam int FRAC_SHIFT  = STATE_FRAC - SAMPLE_FRAC;
   localparam int WHITE_W     = SAMPLE_BITS + FRAC_SHIFT;
   localparam int COEF_FRAC   = 18;
   localparam int COEF_W      = COEF_FRAC + 1;
   // sum of six pole states, delayed term and direct path gets 4 extra bits
   localparam int SUM_W       = STATE_BITS + 4;
   localparam int PROD_W      = SUM_W + COEF_W;
   localparam int ACC_W       = PROD_W - COEF_FRAC;
   localparam int IDX_W       = $clog2(NUM_POLES);

   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_IDLE = 5'd0;
   localparam logic [STEP_W-1:0] STEP_EMIT = 5'd18;

   typedef enum logic [1:0] {
      A_POLE,
      A_WHITE,
      A_SUM
   } a_sel_type;

   typedef enum logic [3:0] {
      CF_POLE0, CF_POLE1, CF_POLE2, CF_POLE3, CF_POLE4, CF_POLE5,
      CF_GAIN0, CF_GAIN1, CF_GAIN2, CF_GAIN3, CF_GAIN4, CF_GAIN5,
      CF_DIRECT, CF_DELAY, CF_SCALE
   } coef_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_WAIT_IN,
      SEQ_EMIT
   } seq_op_type;

   typedef struct packed {
      a_sel_type        a_sel;
      coef_sel_type     coef;
      logic [IDX_W-1:0] pole_idx;
      acc_op_type       acc_op;
      logic             pole_wr;
      logic             sum_add;
      logic             delay_wr;
      seq_op_type       seq;
   } ctrl_type;

   function automatic logic signed [COEF_W-1:0] coef_rom(input coef_sel_type sel);
      logic signed [COEF_W-1:0] c;
      unique case (sel)
         CF_POLE0:  c = 19'sd261845;
         CF_POLE1:  c = 19'sd260393;
         CF_POLE2:  c = 19'sd254018;
         CF_POLE3:  c = 19'sd227148;
         CF_POLE4:  c = 19'sd144179;
         CF_POLE5:  c = -19'sd199649;
         CF_GAIN0:  c = 19'sd14554;
         CF_GAIN1:  c = 19'sd19681;
         CF_GAIN2:  c = 19'sd40331;
         CF_GAIN3:  c = 19'sd81392;
         CF_GAIN4:  c = 19'sd139710;
         CF_GAIN5:  c = -19'sd4430;
         CF_DIRECT: c = 19'sd140562;
         CF_DELAY:  c = 19'sd30389;
         CF_SCALE:  c = 19'sd28836;
         default:   c = '0;
      endcase
      return c;
   endfunction

   function automatic ctrl_type uop(input a_sel_type a, input coef_sel_type cf,
                                    input int idx, input acc_op_type op,
                                    input logic pw, input logic sa, input logic dw,
                                    input seq_op_type sq);
      ctrl_type w;
      w.a_sel    = a;
      w.coef     = cf;
      w.pole_idx = IDX_W'(idx);
      w.acc_op   = op;
      w.pole_wr  = pw;
      w.sum_add  = sa;
      w.delay_wr = dw;
      w.seq      = sq;
      return w;
   endfunction

   // Pole k: multiply old state, then white by gain; the finished state
   // of pole k-1 is written back while pole k's gain product is formed.
   function automatic ctrl_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_type w;
      unique case (step)
         5'd0:  w = uop(A_WHITE, CF_DIRECT, 0, ACC_HOLD, 1'b0, 1'b0, 1'b0, SEQ_WAIT_IN);
         5'd1:  w = uop(A_POLE,  CF_POLE0,  0, ACC_HOLD, 1'b0, 1'b0, 1'b0, SEQ_NEXT);
         5'd2:  w = uop(A_WHITE, CF_GAIN0,  0, ACC_LOAD, 1'b0, 1'b0, 1'b0, SEQ_NEXT);
         5'd3:  w = uop(A_POLE,  CF_POLE1,  1, ACC_ADD,  1'b0, 1'b0, 1'b0, SEQ_NEXT);
         5'd4:  w = uop(A_WHITE, CF_GAIN1,  0, ACC_LOAD, 1'b1, 1'b1, 1'b0, SEQ_NEXT);
         5'd5:  w = uop(A_POLE,  CF_POLE2,  2, ACC_ADD,  1'b0, 1'b0, 1'b0, SEQ_NEXT);
         5'd6:  w = uop(A_WHITE, CF_GAIN2,  1, ACC_LOAD, 1'b1, 1'b1, 1'b0, SEQ_NEXT);
         5'd7:  w = uop(A_POLE,  CF_POLE3,  3, ACC_ADD,  1'b0, 1'b0, 1'b0, SEQ_NEXT);
         5'd8:  w = uop(A_WHITE, CF_GAIN3,  2, ACC_LOAD, 1'b1, 1'b1, 1'b0, SEQ_NEXT);
         5'd9:  w = uop(A_POLE,  CF_POLE4,  4, ACC_ADD,  1'b0, 1'b0, 1'b0, SEQ_NEXT);
         5'd10: w = uop(A_WHITE, CF_GAIN4,  3, ACC_LOAD, 1'b1, 1'b1, 1'b0, SEQ_NEXT);
         5'd11: w = uop(A_POLE,  CF_POLE5,  5, ACC_ADD,  1'b0, 1'b0, 1'b0, SEQ_NEXT);
         5'd12: w = uop(A_WHITE, CF_GAIN5,  4, ACC_LOAD, 1'b1, 1'b1, 1'b0, SEQ_NEXT);
         5'd13: w = uop(A_WHITE, CF_DIRECT, 0, ACC_ADD,  1'b0, 1'b0, 1'b0, SEQ_NEXT);
         5'd14: w = uop(A_WHITE, CF_DELAY,  5, ACC_LOAD, 1'b1, 1'b1, 1'b0, SEQ_NEXT);
         5'd15: w = uop(A_WHITE, CF_DELAY,  0, ACC_LOAD, 1'b0, 1'b1, 1'b0, SEQ_NEXT);
         5'd16: w = uop(A_SUM,   CF_SCALE,  0, ACC_HOLD, 1'b0, 1'b0, 1'b1, SEQ_NEXT);
         5'd17: w = uop(A_SUM,   CF_SCALE,  0, ACC_LOAD, 1'b0, 1'b0, 1'b0, SEQ_NEXT);
         5'd18: w = uop(A_SUM,   CF_SCALE,  0, ACC_HOLD, 1'b0, 1'b0, 1'b0, SEQ_EMIT);
         default: w = uop(A_WHITE, CF_DIRECT, 0, ACC_HOLD, 1'b0, 1'b0, 1'b0, SEQ_EMIT);
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/pink_noise_shaping_filter_unit.sv =====
`timescale 1ns / 1ps
// Pink-noise shaping filter: one signed Q1.15 white sample in, one saturated
// Q1.15 pink sample out, through six one-pole sections (five low-pass), a
// one-sample delayed white term and a direct path, scaled by 0.11.
//
// Channels: req_valid/req_ready carry req_white_sample; rsp_valid/rsp_ready
// carry rsp_pink_sample. A transaction completes when valid and ready are
// both high at a rising clock edge.
//
// A microcode ROM of 19 steps drives one shared 36x19 multiplier and an
// accumulator. A sample is taken in the idle step, and its result is loaded
// into the output register in the emit step; the next sample is accepted in
// the cycle after that, so each sample is finished before the next is taken.
// There is no other multiplier, and every term passes through it.
//
// The result sits in an output register; while the receiver stalls the
// block still takes and processes the next sample, and waits in its last
// step until the register frees up.
//
// Reset (synchronous, active high) clears all filter state and the delayed
// term, drops rsp_valid and returns the sequencer to its idle step.
module pink_noise_shaping_filter_unit import pnsf_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_white_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_pink_sample
);

   logic [STEP_W-1:0]            step_ff, step_in;
   ctrl_type                     ctrl;
   logic signed [STATE_BITS-1:0] pole_ff [NUM_POLES];
   logic signed [STATE_BITS-1:0] delay_ff;
   logic signed [WHITE_W-1:0]    white_ff;
   logic signed [SUM_W-1:0]      sum_ff;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic signed [ACC_W-1:0]      acc_ff;
   logic                         rsp_valid_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff;

   logic signed [SUM_W-1:0]      mul_a;
   logic signed [COEF_W-1:0]     mul_c;
   logic signed [PROD_W-1:0]     prod_rnd;
   logic signed [ACC_W-1:0]      rnd;
   logic signed [STATE_BITS-1:0] acc_sat;
   logic signed [ACC_W-1:0]      out_rnd;
   logic signed [SAMPLE_BITS-1:0] out_sat;
   logic                         in_take, out_free, emit;

   assign ctrl      = ucode_rom(step_ff);
   assign req_ready = (ctrl.seq == SEQ_WAIT_IN);
   assign in_take   = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit      = (ctrl.seq == SEQ_EMIT) && out_free;

   // next step
   always_comb begin
      unique case (ctrl.seq)
         SEQ_WAIT_IN: step_in = in_take ? step_ff + 1'b1 : step_ff;
         SEQ_EMIT:    step_in = out_free ? STEP_IDLE : step_ff;
         default:     step_in = step_ff + 1'b1;
      endcase
   end

   // operand select and shared multiplier
   always_comb begin
      unique case (ctrl.a_sel)
         A_POLE: mul_a = {{(SUM_W-STATE_BITS){pole_ff[ctrl.pole_idx][STATE_BITS-1]}},
                          pole_ff[ctrl.pole_idx]};
         A_WHITE: mul_a = {{(SUM_W-WHITE_W){white_ff[WHITE_W-1]}}, white_ff};
         default: mul_a = sum_ff;
      endcase
      mul_c   = coef_rom(ctrl.coef);
      prod_in = mul_a * mul_c;
   end

   // round half up back to the other operand's format
   assign prod_rnd = prod_ff + (PROD_W'(1) <<< (COEF_FRAC - 1));
   assign rnd      = prod_rnd[PROD_W-1:COEF_FRAC];

   always_comb begin
      if (&acc_ff[ACC_W-1:STATE_BITS-1] || ~|acc_ff[ACC_W-1:STATE_BITS-1]) begin
         acc_sat = acc_ff[STATE_BITS-1:0];
      end else begin
         acc_sat = acc_ff[ACC_W-1] ? {1'b1, {(STATE_BITS-1){1'b0}}}
                                   : {1'b0, {(STATE_BITS-1){1'b1}}};
      end
   end

   // state format to sample format, then clamp
   assign out_rnd = (acc_ff + (ACC_W'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;

   always_comb begin
      if (&out_rnd[ACC_W-1:SAMPLE_BITS-1] || ~|out_rnd[ACC_W-1:SAMPLE_BITS-1]) begin
         out_sat = out_rnd[SAMPLE_BITS-1:0];
      end else begin
         out_sat = out_rnd[ACC_W-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                    : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_IDLE;
         rsp_valid_ff <= 1'b0;
         delay_ff     <= '0;
         for (int i = 0; i < NUM_POLES; i++) begin
            pole_ff[i] <= '0;
         end
      end else begin
         step_ff <= step_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ctrl.pole_wr) begin
            pole_ff[ctrl.pole_idx] <= acc_sat;
         end
         if (ctrl.delay_wr) begin
            delay_ff <= acc_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      unique case (ctrl.acc_op)
         ACC_LOAD: acc_ff <= rnd;
         ACC_ADD:  acc_ff <= acc_ff + rnd;
         default:  acc_ff <= acc_ff;
      endcase
      if (in_take) begin
         white_ff <= {req_white_sample, {FRAC_SHIFT{1'b0}}};
         // the old delayed term seeds the output sum
         sum_ff   <= {{(SUM_W-STATE_BITS){delay_ff[STATE_BITS-1]}}, delay_ff};
      end else if (ctrl.sum_add) begin
         sum_ff   <= sum_ff + {{(SUM_W-STATE_BITS){acc_sat[STATE_BITS-1]}}, acc_sat};
      end
      if (emit) begin
         rsp_data_ff <= out_sat;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pink_sample = rsp_data_ff;

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      in_take |=> !req_ready)
      else $error("sequencer still ready after taking a sample");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_EMIT)
      else $error("microcode step out of range");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(step_ff) == STEP_EMIT)
      else $error("result raised outside the emit step");

endmodule

// ===== verif/pink_noise_shaping_filter_unit_tb.sv =====
`timescale 1ns / 1ps
module pink_noise_shaping_filter_unit_tb;
   import pnsf_pkg::*;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct packed {
      sample_type white;
      logic       known;
      sample_type pink;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 925;
   localparam int PAUSE_AT      = 600;
   localparam int HOLD_AT       = 300;
   localparam int HOLD_CYCLES   = 250;
   localparam sample_type S_MAX = sample_type'(2 ** (SAMPLE_BITS - 1) - 1);
   localparam sample_type S_MIN = sample_type'(2 ** (SAMPLE_BITS - 1));

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   sample_type req_white_sample = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   sample_type rsp_pink_sample;

   // known-answer tag travels with the payload
   logic       cur_known = 1'b0;
   sample_type cur_pink = '0;

   longint  pole_k [NUM_POLES] = '{261845, 260393, 254018, 227148, 144179, -199649};
   longint  gain_k [NUM_POLES] = '{14554, 19681, 40331, 81392, 139710, -4430};
   localparam longint DIRECT_K = 140562;
   localparam longint DELAY_K  = 30389;
   localparam longint SCALE_K  = 28836;

   longint  pole_acc [NUM_POLES];
   longint  delay_term;

   sample_type pink_expected [$];
   int      mismatch_count = 0;
   int      pink_seen = 0;
   bit      send_quiet = 1'b0;

   stim_row_type directed [DIRECTED_ROWS] = '{
      '{16'sd0, 1'b1, 16'sd0},
      '{16'sd0, 1'b1, 16'sd0},
      '{16'sd1, 1'b0, 16'sd0},
      '{-16'sd1, 1'b0, 16'sd0},
      '{S_MIN, 1'b0, 16'sd0},
      '{S_MAX, 1'b0, 16'sd0},
      '{16'sd21845, 1'b0, 16'sd0},
      '{-16'sd21846, 1'b0, 16'sd0},
      '{S_MAX, 1'b0, 16'sd0}, '{S_MAX, 1'b0, 16'sd0},
      '{S_MAX, 1'b0, 16'sd0}, '{S_MAX, 1'b0, 16'sd0},
      '{S_MAX, 1'b0, 16'sd0}, '{S_MAX, 1'b0, 16'sd0},
      '{S_MAX, 1'b0, 16'sd0}, '{S_MAX, 1'b0, 16'sd0},
      '{S_MIN, 1'b0, 16'sd0}, '{S_MIN, 1'b0, 16'sd0},
      '{S_MIN, 1'b0, 16'sd0}, '{S_MIN, 1'b0, 16'sd0},
      '{S_MIN, 1'b0, 16'sd0}, '{S_MIN, 1'b0, 16'sd0},
      '{S_MIN, 1'b0, 16'sd0}, '{S_MIN, 1'b0, 16'sd0},
      '{16'sd0, 1'b0, 16'sd0}
   };

   pink_noise_shaping_filter_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_white_sample (req_white_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pink_sample  (rsp_pink_sample)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("pink_noise_shaping_filter_unit test failed");
      $finish;
   end

   // product with an 18-bit fraction coefficient, rounded half up
   function automatic longint coef_round(input longint a, input longint c);
      return (a * c + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
   endfunction

   function automatic longint clip(input longint v, input int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic sample_type shape_sample(input sample_type white);
      longint w;
      longint sum;
      longint scaled;
      w = longint'(white) * (longint'(1) <<< FRAC_SHIFT);
      for (int i = 0; i < NUM_POLES; i++)
         pole_acc[i] = clip(coef_round(pole_acc[i], pole_k[i]) + coef_round(w, gain_k[i]),
                            STATE_BITS);
      sum = delay_term + coef_round(w, DIRECT_K);
      for (int i = 0; i < NUM_POLES; i++)
         sum += pole_acc[i];
      scaled = coef_round(sum, SCALE_K);
      // delayed term is updated only after the output is formed
      delay_term = clip(coef_round(w, DELAY_K), STATE_BITS);
      return sample_type'(clip((scaled + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT,
                               SAMPLE_BITS));
   endfunction

   always @(posedge clock) begin
      sample_type predicted;
      sample_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = shape_sample(req_white_sample);
            pink_expected.push_back(cur_known ? cur_pink : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            pink_seen++;
            if (pink_expected.size() == 0) begin
               $error("pink_sample: no transaction expected, actual %0d", rsp_pink_sample);
               mismatch_count++;
            end else begin
               want = pink_expected.pop_front();
               if (rsp_pink_sample !== want) begin
                  $error("pink_sample mismatch: expected %0d, actual %0d",
                         want, rsp_pink_sample);
                  mismatch_count++;
               end
            end
         end
      end
   end

   task automatic send_sample(input sample_type s, input logic known, input sample_type pink);
      int unsigned gap;
      gap = send_quiet ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_white_sample <= s;
      cur_known        <= known;
      cur_pink         <= pink;
      do @(posedge clock); while (!req_ready);
   endtask

   // receiver: random stalls, quiet bursts, one long hold-off
   initial begin
      int unsigned stall;
      int burst_left;
      bit held;
      burst_left = 0;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (burst_left == 0 && $urandom_range(0, 9) == 0)
            burst_left = $urandom_range(10, 40);
         if (!held && pink_seen >= HOLD_AT) begin
            stall = HOLD_CYCLES;
            held = 1'b1;
         end else if (burst_left > 0) begin
            stall = 0;
            burst_left--;
         end else begin
            stall = $urandom_range(0, 16);
         end
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      sample_type s;
      sample_type run_val;
      int mode;
      int seg;
      int n;
      int burst_left;
      for (int i = 0; i < NUM_POLES; i++)
         pole_acc[i] = 0;
      delay_term = 0;
      burst_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_sample(directed[i].white, directed[i].known, directed[i].pink);

      n = 0;
      while (n < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 9);
         seg = (mode == 6 || mode == 7) ? $urandom_range(30, 70) : $urandom_range(8, 48);
         run_val = $urandom_range(0, 1) ? S_MAX : S_MIN;
         if (mode == 7)
            run_val = run_val ^ sample_type'($urandom_range(0, 255));
         for (int k = 0; k < seg && n < RANDOM_ITEMS; k++) begin
            case (mode)
               4, 5:    s = sample_type'(int'($urandom_range(0, 511)) - 256);
               6, 7:    s = run_val;
               8:       s = k[0] ? S_MAX : S_MIN;
               9: begin
                  s = sample_type'(1) <<< $urandom_range(0, SAMPLE_BITS - 1);
                  if ($urandom_range(0, 1)) s = ~s;
               end
               default: s = sample_type'($urandom);
            endcase
            if (burst_left == 0 && $urandom_range(0, 15) == 0)
               burst_left = $urandom_range(10, 40);
            send_quiet = (burst_left > 0);
            if (burst_left > 0) burst_left--;
            if (n == PAUSE_AT) begin
               // let the filter drain completely before going on
               req_valid <= 1'b0;
               do @(posedge clock); while (pink_expected.size() != 0);
            end
            send_sample(s, 1'b0, '0);
            n++;
         end
      end
      req_valid <= 1'b0;

      while (pink_expected.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && pink_expected.size() == 0)
         $display("pink_noise_shaping_filter_unit test passed");
      else
         $display("pink_noise_shaping_filter_unit test failed");
      $finish;
   end

endmodule
